[rtl/btkhs_pkg.sv]
// Package with widths, codes and the entry type of the beam top-K heap selector.
`timescale 1ns / 1ps
`default_nettype none

package btkhs_pkg;

  // Number of candidates kept per time step, and the index widths that follow.
  localparam int BEAM_WIDTH = 512;
  localparam int IDX_W      = $clog2(BEAM_WIDTH);
  localparam int CNT_W      = $clog2(BEAM_WIDTH + 1);

  // Field widths of one beat.
  localparam int SCORE_W  = 32;
  localparam int STATE_W  = 12;
  localparam int TAG_W    = 13;
  localparam int SLOT_W   = 10;
  localparam int FILL_W   = 10;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  // Packed beat widths, rounded up to whole bytes.
  localparam int IN_BITS    = SCORE_W + STATE_W + TAG_W + SLOT_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = SCORE_W + STATE_W + TAG_W + FILL_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes carried in the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_OFFER = 2'd1,
    OP_READ  = 2'd2,
    OP_FIND  = 2'd3
  } op_e;

  // Result codes carried in the output tuser.
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_KEPT     = 3'd2,
    ST_DONE     = 3'd3,
    ST_MISS     = 3'd4
  } status_e;

  // One heap entry as held in the store.
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic        [STATE_W-1:0] state_id;
    logic signed [TAG_W-1:0]   tag;
  } entry_t;

endpackage

`default_nettype wire

[rtl/beam_top_k_heap_selector.sv]
// Top level of the beam top-K heap selector: sequencer, entry store and sift unit.
//
//  channel | dir | handshake                     | payload
//  --------+-----+-------------------------------+--------------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tuser opcode, tdata score..slot
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tuser status, tdata score..fill_count
//
//  One operation is in flight at a time; the entry memory with one registered read sets the pace.
//  An offer into a full store is kept out unless it beats the root, else it replaces the root and
//  sifts down; a find scans the entries in order. The offer that fills the store runs a bottom-up
//  heapify. Reset clears the sequencer, the fill count and the output valid, not the entry store;
//  a result not yet taken stalls the output.
`timescale 1ns / 1ps
`default_nettype none

module beam_top_k_heap_selector (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  // tdata: score [31:0], state_id [43:32], tag [56:44], slot [66:57], zero pad above
  input  wire logic [btkhs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: opcode [1:0]
  input  wire logic [btkhs_pkg::OP_W-1:0]       s_axis_tuser,
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // tdata: out_score [31:0], out_state [43:32], out_tag [56:44], fill_count [66:57]
  output      logic [btkhs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: status [2:0]
  output      logic [btkhs_pkg::STATUS_W-1:0]   m_axis_tuser
);

  localparam int N     = btkhs_pkg::BEAM_WIDTH;
  localparam int IDX_W = btkhs_pkg::IDX_W;
  localparam int CNT_W = btkhs_pkg::CNT_W;
  localparam int CMP_W = (CNT_W > btkhs_pkg::SLOT_W) ? CNT_W : btkhs_pkg::SLOT_W;
  localparam int OUT_PAD = btkhs_pkg::OUT_DATA_W - btkhs_pkg::OUT_BITS;

  // Result entry of an invalid read or a failed find.
  localparam btkhs_pkg::entry_t MISS_ENT = '{score: '0, state_id: '0, tag: '1};

  typedef enum logic [3:0] {
    S_IDLE,
    S_OFFER_CMP,
    S_HEAP_RD,
    S_HEAP_KEY,
    S_SIFT_L,
    S_SIFT_R,
    S_SIFT_CMP,
    S_READ_DATA,
    S_FIND_CHK,
    S_OUT
  } state_e;

  state_e                    state_q;
  logic [CNT_W-1:0]          count_q;
  btkhs_pkg::entry_t         cand_q;
  btkhs_pkg::entry_t         key_q;
  btkhs_pkg::entry_t         left_q;
  logic [IDX_W-1:0]          par_q;
  logic [IDX_W-1:0]          chd_q;
  logic                      rok_q;
  logic [IDX_W-1:0]          node_q;
  logic                      heap_q;
  logic [IDX_W-1:0]          idx_q;
  btkhs_pkg::status_e        res_status_q;
  btkhs_pkg::entry_t         res_ent_q;
  logic                      m_valid_q;
  logic [btkhs_pkg::OUT_DATA_W-1:0] m_data_q;
  logic [btkhs_pkg::STATUS_W-1:0]   m_user_q;

  // Entry store, one write and one registered read per cycle.
  btkhs_pkg::entry_t         mem [N];
  btkhs_pkg::entry_t         rdata_q;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  btkhs_pkg::entry_t         mem_wdata;
  logic [IDX_W-1:0]          mem_raddr;

  // Unpacked input beat.
  btkhs_pkg::op_e            in_op;
  btkhs_pkg::entry_t         in_ent;
  logic [btkhs_pkg::SLOT_W-1:0] in_slot;
  logic [btkhs_pkg::SLOT_W-1:0] slot_m1;
  logic                      in_accept;
  logic                      not_full;
  logic                      slot_ok;
  logic                      out_load;

  // Sift unit signals.
  logic [IDX_W:0]            lchild;
  logic [IDX_W:0]            rchild;
  logic                      l_exists;
  logic                      r_exists;
  logic                      take_right;
  btkhs_pkg::entry_t         pick;
  logic [IDX_W-1:0]          pick_idx;
  logic                      key_stays;
  logic                      heap_more;
  logic                      find_hit;
  logic                      find_last;

  assign in_op            = btkhs_pkg::op_e'(s_axis_tuser);
  assign in_ent.score     = s_axis_tdata[btkhs_pkg::SCORE_W-1:0];
  assign in_ent.state_id  = s_axis_tdata[btkhs_pkg::SCORE_W +: btkhs_pkg::STATE_W];
  assign in_ent.tag       = s_axis_tdata[btkhs_pkg::SCORE_W + btkhs_pkg::STATE_W +:
                                         btkhs_pkg::TAG_W];
  assign in_slot          = s_axis_tdata[btkhs_pkg::SCORE_W + btkhs_pkg::STATE_W +
                                         btkhs_pkg::TAG_W +: btkhs_pkg::SLOT_W];
  assign slot_m1          = in_slot - 1'b1;

  assign s_axis_tready    = (state_q == S_IDLE);
  assign in_accept        = s_axis_tvalid && s_axis_tready;
  assign not_full         = (count_q < CNT_W'(N));
  assign slot_ok          = (in_slot != '0) && (CMP_W'(in_slot) <= CMP_W'(count_q));
  assign out_load         = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

  // Child selection and the compare of the sifted key.
  assign lchild     = {par_q, 1'b1};
  assign rchild     = {1'b0, chd_q} + 1'b1;
  assign l_exists   = (lchild < (IDX_W + 1)'(N));
  assign r_exists   = (rchild < (IDX_W + 1)'(N));
  assign take_right = rok_q && ($signed(left_q.score) > $signed(rdata_q.score));
  assign pick       = take_right ? rdata_q : left_q;
  assign pick_idx   = take_right ? rchild[IDX_W-1:0] : chd_q;
  assign key_stays  = ($signed(key_q.score) <= $signed(pick.score));
  assign heap_more  = heap_q && (node_q != IDX_W'(1));

  // Linear scan for find.
  assign find_hit   = (rdata_q.state_id == cand_q.state_id);
  assign find_last  = (CNT_W'(idx_q) + 1'b1 == count_q);

  // Memory port control per sequencer state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = par_q;
    mem_wdata = key_q;
    mem_raddr = '0;
    case (state_q)
      S_IDLE: begin
        mem_waddr = count_q[IDX_W-1:0];
        mem_wdata = in_ent;
        mem_we    = in_accept && (in_op == btkhs_pkg::OP_OFFER) && not_full;
        if (in_op == btkhs_pkg::OP_READ) begin
          mem_raddr = IDX_W'(slot_m1);
        end
      end
      S_HEAP_RD: begin
        mem_raddr = node_q - 1'b1;
      end
      S_SIFT_L: begin
        mem_we    = !l_exists;
        mem_raddr = lchild[IDX_W-1:0];
      end
      S_SIFT_R: begin
        mem_raddr = rchild[IDX_W-1:0];
      end
      S_SIFT_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = key_stays ? key_q : pick;
      end
      S_FIND_CHK: begin
        mem_raddr = idx_q + 1'b1;
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  // Entry store.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      heap_q       <= 1'b0;
      m_valid_q    <= 1'b0;
      res_status_q <= btkhs_pkg::ST_DONE;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            cand_q    <= in_ent;
            idx_q     <= '0;
            case (in_op)
              btkhs_pkg::OP_CLEAR: begin
                count_q      <= '0;
                res_ent_q    <= '0;
                res_status_q <= btkhs_pkg::ST_DONE;
                state_q      <= S_OUT;
              end
              btkhs_pkg::OP_OFFER: begin
                res_ent_q <= '0;
                if (not_full) begin
                  count_q      <= count_q + 1'b1;
                  res_status_q <= btkhs_pkg::ST_INSERTED;
                  if (count_q == CNT_W'(N - 1)) begin
                    heap_q  <= 1'b1;
                    node_q  <= IDX_W'(N / 2);
                    state_q <= S_HEAP_RD;
                  end else begin
                    state_q <= S_OUT;
                  end
                end else begin
                  state_q <= S_OFFER_CMP;
                end
              end
              btkhs_pkg::OP_READ: begin
                if (slot_ok) begin
                  state_q <= S_READ_DATA;
                end else begin
                  res_status_q <= btkhs_pkg::ST_MISS;
                  res_ent_q    <= MISS_ENT;
                  state_q      <= S_OUT;
                end
              end
              btkhs_pkg::OP_FIND: begin
                if (count_q == '0) begin
                  res_status_q <= btkhs_pkg::ST_MISS;
                  res_ent_q    <= MISS_ENT;
                  state_q      <= S_OUT;
                end else begin
                  res_ent_q <= '0;
                  state_q   <= S_FIND_CHK;
                end
              end
              default: begin
                res_ent_q <= '0;
                state_q   <= S_OUT;
              end
            endcase
          end
        end
        // Full store: the candidate must beat the root.
        S_OFFER_CMP: begin
          if ($signed(cand_q.score) > $signed(rdata_q.score)) begin
            key_q        <= cand_q;
            par_q        <= '0;
            heap_q       <= 1'b0;
            res_status_q <= btkhs_pkg::ST_REPLACED;
            state_q      <= S_SIFT_L;
          end else begin
            res_status_q <= btkhs_pkg::ST_KEPT;
            state_q      <= S_OUT;
          end
        end
        S_HEAP_RD: begin
          state_q <= S_HEAP_KEY;
        end
        S_HEAP_KEY: begin
          key_q   <= rdata_q;
          par_q   <= node_q - 1'b1;
          state_q <= S_SIFT_L;
        end
        // Left child read is issued; a leaf parent takes the key here.
        S_SIFT_L: begin
          if (l_exists) begin
            chd_q   <= lchild[IDX_W-1:0];
            state_q <= S_SIFT_R;
          end else if (heap_more) begin
            node_q  <= node_q - 1'b1;
            state_q <= S_HEAP_RD;
          end else begin
            heap_q  <= 1'b0;
            state_q <= S_OUT;
          end
        end
        S_SIFT_R: begin
          left_q  <= rdata_q;
          rok_q   <= r_exists;
          state_q <= S_SIFT_CMP;
        end
        // Either the key settles at the parent or the smaller child moves up.
        S_SIFT_CMP: begin
          if (!key_stays) begin
            par_q   <= pick_idx;
            state_q <= S_SIFT_L;
          end else if (heap_more) begin
            node_q  <= node_q - 1'b1;
            state_q <= S_HEAP_RD;
          end else begin
            heap_q  <= 1'b0;
            state_q <= S_OUT;
          end
        end
        S_READ_DATA: begin
          res_ent_q    <= rdata_q;
          res_status_q <= btkhs_pkg::ST_DONE;
          state_q      <= S_OUT;
        end
        S_FIND_CHK: begin
          if (find_hit) begin
            res_ent_q    <= rdata_q;
            res_status_q <= btkhs_pkg::ST_DONE;
            state_q      <= S_OUT;
          end else if (find_last) begin
            res_ent_q.tag <= '1;
            res_status_q  <= btkhs_pkg::ST_MISS;
            state_q       <= S_OUT;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        // Hand the result to the output register once it is free.
        S_OUT: begin
          if (out_load) begin
            m_user_q  <= res_status_q;
            m_data_q  <= {{OUT_PAD{1'b0}}, btkhs_pkg::FILL_W'(count_q), res_ent_q.tag,
                          res_ent_q.state_id, res_ent_q.score};
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // The fill count never passes the beam width.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(N))
    else $error("fill count above beam width");

  // Sifting only ever runs on a full store.
  a_sift_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SIFT_L || state_q == S_SIFT_R || state_q == S_SIFT_CMP) |->
    count_q == CNT_W'(N))
    else $error("sift on a store that is not full");

  // An accepted offer on a store with room adds exactly one entry.
  a_offer_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_op == btkhs_pkg::OP_OFFER && not_full) |=>
    count_q == $past(count_q) + 1'b1)
    else $error("offer did not grow the store");

  // An accepted clear empties the store.
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_op == btkhs_pkg::OP_CLEAR) |=> count_q == '0)
    else $error("clear left entries behind");

endmodule

`default_nettype wire
